// ===== rtl/core/sectioned_sorted_int_set_unit_defines.svh =====
// ============================================================================
// sectioned_sorted_int_set_unit_defines.svh
// Assertion macros used by the checker file of the set unit.
// ============================================================================
`ifndef SECTIONED_SORTED_INT_SET_UNIT_DEFINES_SVH
`define SECTIONED_SORTED_INT_SET_UNIT_DEFINES_SVH

// same-cycle implication
`define SSSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sssi_pkg.sv =====
// ============================================================================
// sssi_pkg
// Types and constants of the sectioned sorted integer set unit.
// ============================================================================
package sssi_pkg;

    localparam int VALUE_W      = 24;
    localparam int SECTION_BITS = 16;
    localparam int LOW_W        = SECTION_BITS;
    localparam int SEC_W        = VALUE_W - SECTION_BITS;
    localparam int NUM_SECTIONS = 1 << SEC_W;
    localparam int CNT_W        = 13;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 24;
    localparam int MAX_ELEM_W   = 24;

    localparam logic [MAX_ELEM_W-1:0] MAX_ELEM_RST = 24'hFF_FFFF;
    localparam logic [CNT_W-1:0]      CAP_RST      = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_MEMBER = 2'd1,
        CMD_COUNT  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_ABOVE_MAX = 2'd2,
        ST_NOT_ASC   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ELEMENT    = 1'b0,
        REG_CAPACITY_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SKIP,
        S_FIN,
        S_QA,
        S_QB,
        S_SEARCH,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t          status;
        logic             is_member;
        logic [CNT_W-1:0] count;
    } rsp_t;

endpackage

// ===== rtl/core/sssi_if.sv =====
// ============================================================================
// sssi_if
// Channel interfaces of the set unit: request, response, configuration.
// ============================================================================
interface sssi_req_if import sssi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface sssi_rsp_if import sssi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_member;
    logic [CNT_W-1:0]    count;

    modport source (output valid, output status, output is_member, output count,
                    input ready);
    modport sink   (input valid, input status, input is_member, input count,
                    output ready);
endinterface

interface sssi_cfg_if import sssi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sssi_ram.sv =====
// ============================================================================
// sssi_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module sssi_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 13,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sectioned_sorted_int_set_unit.sv =====
// ============================================================================
// sectioned_sorted_int_set_unit
// Ascending integer set: low parts in a store RAM, section starts in a table
// RAM. Adds append; member and count queries binary-search one section.
// ============================================================================
//  channel | role    | payload
//  req     | sink    | command, value
//  rsp     | source  | status, is_member, count
//  cfg     | sink    | index, data (always ready)
//
//  One item at a time. Query: S_QA, S_QB, then S_SEARCH for the binary-search
//  probes (at most 13), one store RAM read per cycle. Add: S_ADD, S_SKIP per
//  section passed (one table RAM write per cycle), S_FIN. A rejected add, a
//  member query above max or an unused command goes straight to S_RESULT.
//  req.ready rises with rsp.valid; a stalled rsp holds only the next result.
//  Reset is asynchronous; no clearing pass.
// ============================================================================
module sectioned_sorted_int_set_unit
    import sssi_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    sssi_req_if.sink   req,
    sssi_rsp_if.source rsp,
    sssi_cfg_if.sink   cfg
);

    localparam int ST_AW = $clog2(STORE_DEPTH);

    state_t                state_reg, state_next;
    logic [MAX_ELEM_W-1:0] max_elem_reg;
    logic [CNT_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [SEC_W-1:0]      cur_sec_reg, cur_sec_next;
    logic [VALUE_W-1:0]    last_value_reg, last_value_next;
    logic                  any_added_reg, any_added_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [CNT_W-1:0]      begin_reg, begin_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      mid_reg, mid_next;
    logic                  pend_reg, pend_next;
    logic [LOW_W-1:0]      last_le_reg, last_le_next;
    rsp_t                  stage_reg, stage_next;
    rsp_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [SEC_W-1:0] sec;
    logic [LOW_W-1:0] key;
    logic             full;

    logic             tbl_we, tbl_re;
    logic [SEC_W-1:0] tbl_waddr, tbl_raddr;
    logic [CNT_W-1:0] tbl_rdata;

    logic             st_we, st_re;
    logic [LOW_W-1:0] st_rdata;

    logic             le_hit;
    logic [CNT_W-1:0] lo_c, hi_c, mid_c;
    logic [LOW_W-1:0] last_le_c;
    logic             out_free;

    assign sec  = value_reg[VALUE_W-1:SECTION_BITS];
    assign key  = value_reg[LOW_W-1:0];
    assign full = (32'(fill_reg) >= 32'(cap_reg)) || (32'(fill_reg) >= STORE_DEPTH);

    // search step: resolve the probe in flight, then pick the next midpoint
    assign le_hit    = pend_reg && (st_rdata <= key);
    assign lo_c      = le_hit ? mid_reg + 1'b1 : lo_reg;
    assign hi_c      = (pend_reg && !le_hit) ? mid_reg : hi_reg;
    assign last_le_c = le_hit ? st_rdata : last_le_reg;
    assign mid_c     = lo_c + ((hi_c - lo_c) >> 1);

    assign out_free = !out_valid_reg || rsp.ready;

    sssi_ram #(
        .DEPTH (NUM_SECTIONS),
        .WIDTH (CNT_W)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (fill_reg),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sssi_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (LOW_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (ST_AW'(fill_reg)),
        .wdata (key),
        .re    (st_re),
        .raddr (ST_AW'(mid_c)),
        .rdata (st_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cur_sec_next    = cur_sec_reg;
        last_value_next = last_value_reg;
        any_added_next  = any_added_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        begin_next      = begin_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pend_next       = pend_reg;
        last_le_next    = last_le_reg;
        stage_next      = stage_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = cur_sec_reg + 1'b1;
        tbl_re          = 1'b0;
        tbl_raddr       = req.value[VALUE_W-1:SECTION_BITS];
        st_we           = 1'b0;
        st_re           = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    value_next = req.value;
                    case (req.command)
                        CMD_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        CMD_MEMBER, CMD_COUNT:
                        begin
                            tbl_re     = 1'b1;
                            state_next = S_QA;
                        end
                        default:
                        begin
                            stage_next = '0;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                stage_next.is_member = 1'b0;
                stage_next.count     = fill_reg;
                if (full)
                begin
                    stage_next.status = ST_FULL;
                    state_next        = S_RESULT;
                end
                else if (value_reg > max_elem_reg)
                begin
                    stage_next.status = ST_ABOVE_MAX;
                    state_next        = S_RESULT;
                end
                else if (any_added_reg && (value_reg <= last_value_reg))
                begin
                    stage_next.status = ST_NOT_ASC;
                    state_next        = S_RESULT;
                end
                else
                begin
                    st_we      = 1'b1;
                    state_next = (cur_sec_reg < sec) ? S_SKIP : S_FIN;
                end
            end

            S_SKIP:
            begin
                tbl_we       = 1'b1;
                cur_sec_next = cur_sec_reg + 1'b1;
                if (cur_sec_next == sec)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                fill_next            = fill_reg + 1'b1;
                last_value_next      = value_reg;
                any_added_next       = 1'b1;
                stage_next.status    = ST_OK;
                stage_next.is_member = 1'b0;
                stage_next.count     = fill_reg + 1'b1;
                state_next           = S_RESULT;
            end

            S_QA:
            begin
                // table data for this section; fetch the next section's start
                tbl_re    = 1'b1;
                tbl_raddr = sec + 1'b1;
                if (sec == '0)
                begin
                    begin_next = '0;
                end
                else if (sec <= cur_sec_reg)
                begin
                    begin_next = tbl_rdata;
                end
                else
                begin
                    begin_next = fill_reg;
                end
                if ((cmd_reg == CMD_MEMBER) && (value_reg > max_elem_reg))
                begin
                    stage_next = '0;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_QB;
                end
            end

            S_QB:
            begin
                lo_next    = begin_reg;
                hi_next    = (sec < cur_sec_reg) ? tbl_rdata : fill_reg;
                pend_next  = 1'b0;
                state_next = S_SEARCH;
            end

            S_SEARCH:
            begin
                lo_next      = lo_c;
                hi_next      = hi_c;
                last_le_next = last_le_c;
                if (lo_c < hi_c)
                begin
                    st_re     = 1'b1;
                    mid_next  = mid_c;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next         = 1'b0;
                    stage_next.status = ST_OK;
                    if (cmd_reg == CMD_MEMBER)
                    begin
                        stage_next.is_member = (lo_c > begin_reg) && (last_le_c == key);
                        stage_next.count     = '0;
                    end
                    else
                    begin
                        stage_next.is_member = 1'b0;
                        stage_next.count     = lo_c;
                    end
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_next       = stage_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_elem_reg   <= MAX_ELEM_RST;
            cap_reg        <= CAP_RST;
            fill_reg       <= '0;
            cur_sec_reg    <= '0;
            last_value_reg <= '0;
            any_added_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_reg       <= fill_next;
            cur_sec_reg    <= cur_sec_next;
            last_value_reg <= last_value_next;
            any_added_reg  <= any_added_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MAX_ELEMENT:
                    begin
                        max_elem_reg <= cfg.data[MAX_ELEM_W-1:0];
                    end
                    REG_CAPACITY_LIMIT:
                    begin
                        cap_reg <= cfg.data[CNT_W-1:0];
                    end
                    default:
                    begin
                        max_elem_reg <= max_elem_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        begin_reg   <= begin_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        last_le_reg <= last_le_next;
        stage_reg   <= stage_next;
        out_reg     <= out_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.is_member = out_reg.is_member;
    assign rsp.count     = out_reg.count;

endmodule

// ===== rtl/core/sssi_chk.sv =====
// ============================================================================
// sssi_chk
// Port-level checker for the set unit, bound to the top level.
// ============================================================================
`include "sectioned_sorted_int_set_unit_defines.svh"

module sssi_chk
    import sssi_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_is_member,
    input logic [CNT_W-1:0]    rsp_count
);

    // one item in flight: ready drops after an accept
    `SSSI_ASSERT_NXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "item accepted while busy")

    `SSSI_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_is_member) && $stable(rsp_count), "stalled response changed")

    // a member hit comes only from a membership query
    `SSSI_ASSERT_IMP(a_member_fields, clk, rst_n, rsp_valid && rsp_is_member, (rsp_status == ST_OK) && (rsp_count == '0), "member hit with status or count")

    `SSSI_ASSERT_IMP(a_err_no_member, clk, rst_n, rsp_valid && (rsp_status != ST_OK), !rsp_is_member, "error response flags member")

endmodule

bind sectioned_sorted_int_set_unit sssi_chk u_sssi_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_is_member (rsp.is_member),
    .rsp_count     (rsp.count)
);

// ===== tb/sectioned_sorted_int_set_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sectioned_sorted_int_set_unit_tb
// Drives add, member, count and unused commands into the set unit and
// compares every response, field by field, against a cycle-free model of
// the set kept inside this bench. Both channels idle at random; the
// registers are rewritten between phases, extremes included.
// ============================================================================
module sectioned_sorted_int_set_unit_tb;
    import sssi_pkg::*;

    localparam int          STORE_DEPTH = 4096;
    localparam int          RANDOM_ITEMS = 475;
    localparam int          DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] TOP_VALUE  = {VALUE_W{1'b1}};

    logic clk;
    logic rst_n;

    sssi_req_if req_if ();
    sssi_rsp_if rsp_if ();
    sssi_cfg_if cfg_if ();

    sectioned_sorted_int_set_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if),
        .cfg  (cfg_if)
    );

    // set model
    logic [LOW_W-1:0]   low_parts [STORE_DEPTH];
    int unsigned        section_starts [NUM_SECTIONS+1];
    int unsigned        fill;
    int unsigned        cur_section;
    logic [VALUE_W-1:0] last_added;
    bit                 anything_added;
    logic [VALUE_W-1:0] max_elem_reg;
    logic [CNT_W-1:0]   cap_reg;

    rsp_t               awaited_answers [$];
    logic [VALUE_W-1:0] set_members [$];
    int unsigned        error_count;
    int unsigned        cycle_count;
    bit                 no_gaps;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned section_first(int unsigned s);
        return (s <= cur_section) ? section_starts[s] : fill;
    endfunction

    function automatic int unsigned section_last(int unsigned s);
        return (s < cur_section) ? section_starts[s+1] : fill;
    endfunction

    // index just past the last entry in [lo,hi) whose low part is <= key
    function automatic int unsigned search_past(int unsigned lo, int unsigned hi,
                                                int unsigned key);
        int unsigned mid;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (low_parts[mid] <= key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic rsp_t predict_answer(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
        rsp_t        ans;
        int unsigned s;
        int unsigned key;
        int unsigned lim;
        int unsigned b;
        int unsigned c;
        ans = '0;
        s = 32'(val[VALUE_W-1:SECTION_BITS]);
        key = 32'(val[LOW_W-1:0]);
        case (cmd)
            CMD_ADD:
            begin
                lim = (cap_reg < STORE_DEPTH) ? cap_reg : STORE_DEPTH;
                if (fill >= lim)
                    ans.status = ST_FULL;
                else if (val > max_elem_reg)
                    ans.status = ST_ABOVE_MAX;
                else if (anything_added && val <= last_added)
                    ans.status = ST_NOT_ASC;
                else
                begin
                    while (cur_section < s && cur_section < NUM_SECTIONS - 1)
                    begin
                        section_starts[cur_section+1] = fill;
                        cur_section++;
                    end
                    low_parts[fill] = LOW_W'(key);
                    fill++;
                    last_added = val;
                    anything_added = 1'b1;
                    set_members.push_back(val);
                end
                ans.count = CNT_W'(fill);
            end
            CMD_MEMBER:
            begin
                if (val <= max_elem_reg)
                begin
                    b = section_first(s);
                    c = search_past(b, section_last(s), key);
                    if (c > b && low_parts[c-1] == key)
                        ans.is_member = 1'b1;
                end
            end
            CMD_COUNT:
                ans.count = CNT_W'(search_past(section_first(s), section_last(s), key));
            default:
                ;
        endcase
        return ans;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_ascending();
        int unsigned base;
        int unsigned step;
        int unsigned r;
        base = anything_added ? last_added + 32'd1 : 32'd0;
        r = $urandom_range(0, 99);
        if (r < 60)
            step = $urandom_range(0, 7);
        else if (r < 85)
            step = $urandom_range(0, 1999);
        else if (r < 95)
            step = $urandom_range(0, 65535);
        else
            step = $urandom_range(0, 262143);
        if (base > max_elem_reg)
            return VALUE_W'($urandom_range(0, last_added));
        if (base + step > max_elem_reg)
            return VALUE_W'($urandom_range(max_elem_reg, base));
        return VALUE_W'(base + step);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_broken_add();
        if (max_elem_reg != TOP_VALUE && $urandom_range(0, 1) == 1)
            return VALUE_W'($urandom_range(max_elem_reg + 32'd1, TOP_VALUE));
        return VALUE_W'($urandom_range(0, last_added));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_query_value();
        int unsigned r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (set_members.size() == 0 || r < 25)
            return VALUE_W'($urandom);
        v = set_members[$urandom_range(0, set_members.size() - 1)];
        if (r < 70)
            return v;
        if (r < 85)
            return VALUE_W'(v + $urandom_range(1, 3));
        return VALUE_W'(v - $urandom_range(1, 3));
    endfunction

    task automatic report_failure(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    // leaves valid high after acceptance; the next call or drain_answers moves it
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
        int unsigned gap;
        gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.value   <= val;
        do @(posedge clk); while (!req_if.ready);
        awaited_answers.push_back(predict_answer(cmd, val));
    endtask

    task automatic drain_answers();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == REG_MAX_ELEMENT)
            max_elem_reg = data[MAX_ELEM_W-1:0];
        else
            cap_reg = data[CNT_W-1:0];
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_empty_set();
        send_item(CMD_MEMBER, '0);
        send_item(CMD_COUNT, '0);
        send_item(CMD_MEMBER, TOP_VALUE);
        send_item(CMD_COUNT, TOP_VALUE);
    endtask

    task automatic test_add_sequence();
        send_item(CMD_ADD, 24'h00_0000);
        send_item(CMD_ADD, 24'h00_0000);
        send_item(CMD_ADD, 24'h00_0001);
        send_item(CMD_ADD, 24'h00_FFFF);
        send_item(CMD_ADD, 24'h01_0000);
        send_item(CMD_ADD, 24'h03_0005);
        send_item(CMD_ADD, 24'h02_FFFF);
    endtask

    task automatic test_section_queries();
        send_item(CMD_MEMBER, 24'h00_0002);
        send_item(CMD_MEMBER, 24'h00_FFFF);
        send_item(CMD_MEMBER, 24'h02_0000);
        send_item(CMD_MEMBER, 24'h03_0005);
        send_item(CMD_MEMBER, 24'h40_0000);
        send_item(CMD_COUNT, 24'h00_FFFE);
        send_item(CMD_COUNT, 24'h02_0000);
        send_item(CMD_COUNT, 24'h03_0004);
        send_item(CMD_COUNT, 24'h40_0000);
        send_item(CMD_UNUSED, 24'h03_0005);
    endtask

    task automatic test_register_extremes();
        drain_answers();
        write_register(REG_MAX_ELEMENT, '0);
        write_register(REG_CAPACITY_LIMIT, '0);
        send_item(CMD_ADD, 24'h03_0006);
        send_item(CMD_MEMBER, 24'h00_0001);
        send_item(CMD_MEMBER, 24'h00_0000);
        send_item(CMD_COUNT, 24'h03_0005);
        drain_answers();
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(CAP_RST));
        send_item(CMD_ADD, 24'h03_0006);
        send_item(CMD_ADD, 24'h00_0000);
        drain_answers();
        write_register(REG_MAX_ELEMENT, TOP_VALUE);
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(13'h1FFF));
        send_item(CMD_ADD, 24'h03_0010);
        drain_answers();
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(fill));
        send_item(CMD_ADD, 24'h03_0011);
        drain_answers();
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(1));
        send_item(CMD_ADD, 24'h03_0011);
        drain_answers();
    endtask

    task automatic run_random_phase(int items);
        int sent;
        int unsigned r;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)
                send_item(CMD_ADD, ($urandom_range(0, 9) < 8) ? pick_ascending()
                                                               : pick_broken_add());
            else if (r < 68)
                send_item(CMD_MEMBER, pick_query_value());
            else if (r < 98)
                send_item(CMD_COUNT, pick_query_value());
            else
            begin
                send_item(CMD_UNUSED, VALUE_W'($urandom));
                continue;
            end
            sent++;
        end
        drain_answers();
    endtask

    task automatic test_random_traffic();
        int unsigned bound;
        no_gaps = 1'b1;
        write_register(REG_MAX_ELEMENT, TOP_VALUE);
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(CAP_RST));
        run_random_phase(RANDOM_ITEMS);
        no_gaps = 1'b0;
        bound = last_added + 32'd2_000_000;
        write_register(REG_MAX_ELEMENT, (bound > TOP_VALUE) ? TOP_VALUE : CFG_DATA_W'(bound));
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(13'h1FFF));
        run_random_phase(RANDOM_ITEMS);
        write_register(REG_MAX_ELEMENT, TOP_VALUE);
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(fill + 40));
        run_random_phase(RANDOM_ITEMS);
        write_register(REG_CAPACITY_LIMIT, CFG_DATA_W'(CAP_RST));
        run_random_phase(RANDOM_ITEMS);
    endtask

    task automatic test_top_of_range();
        send_item(CMD_ADD, TOP_VALUE);
        send_item(CMD_MEMBER, TOP_VALUE);
        send_item(CMD_COUNT, TOP_VALUE);
        send_item(CMD_COUNT, 24'hFF_0000);
        send_item(CMD_ADD, TOP_VALUE);
        drain_answers();
    endtask

    // response sink with random stalls
    initial begin
        int unsigned stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 99) < 25)
                    stall = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_ans;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (awaited_answers.size() == 0)
                report_failure($sformatf("unexpected result: status %0d member %0d count %0d",
                                         rsp_if.status, rsp_if.is_member, rsp_if.count));
            else
            begin
                exp_ans = awaited_answers.pop_front();
                if (rsp_if.status !== exp_ans.status || rsp_if.is_member !== exp_ans.is_member
                    || rsp_if.count !== exp_ans.count)
                    report_failure($sformatf(
                        "mismatch: exp status %0d member %0d count %0d, got %0d %0d %0d",
                        exp_ans.status, exp_ans.is_member, exp_ans.count,
                        rsp_if.status, rsp_if.is_member, rsp_if.count));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.command = '0;
        req_if.value   = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_MAX_ELEMENT;
        cfg_if.data    = '0;
        error_count    = 0;
        no_gaps        = 1'b0;
        foreach (section_starts[i])
            section_starts[i] = 0;
        fill           = 0;
        cur_section    = 0;
        last_added     = '0;
        anything_added = 1'b0;
        max_elem_reg   = MAX_ELEM_RST;
        cap_reg        = CAP_RST;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_set();
        test_add_sequence();
        test_section_queries();
        test_register_extremes();
        test_random_traffic();
        test_top_of_range();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_answers.size() != 0)
            report_failure($sformatf("%0d results never arrived", awaited_answers.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sssi_pkg.sv
rtl/core/sssi_if.sv
rtl/core/sssi_ram.sv
rtl/core/sectioned_sorted_int_set_unit.sv
rtl/core/sssi_chk.sv
tb/sectioned_sorted_int_set_unit_tb.sv
